// ----- design/rfr_pkg.sv -----
// shared types, codes and constants for the response frame receiver
package rfr_pkg;

    localparam int unsigned PAYLOAD_LEN_DEF = 8;
    localparam int unsigned PAYLOAD_LEN_MAX = 64;

    localparam int unsigned CMD_W    = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TICK_W   = 16;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 4;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'h00;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_CS_ERR  = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER  = 1'd0,
        REG_TIMEOUT = 1'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HUNT = 3'd1,
        PH_CMD  = 3'd2,
        PH_DATA = 3'd3,
        PH_CS   = 3'd4
    } t_phase;

endpackage

// ----- design/response_frame_receiver_core.sv -----
// response frame receiver: header hunt, command match, payload pass-through, xor check
//
// Each transfer on the input stream is a start, a received byte or a one-millisecond tick
// and produces exactly one result transfer. Every item is handled by
// the frame state machine and its result lands in an output register, so a new item is
// taken every cycle while the output side keeps up; a result waiting on a stalled output
// holds the input back only until it is taken. A start arms a receive for the given
// command; the block then hunts for the header byte, checks the command byte, passes
// PAYLOAD_LEN payload bytes out with their index and compares the final byte with the
// xor of command and payload. Ticks time the receive out once the elapsed count reaches
// timeout_ticks. Bytes and ticks outside a receive give an all-zero result.
module response_frame_receiver_core
    import rfr_pkg::*;
#(
    parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] request_cmd, [15:8] rx_byte
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [5:0] data_index, [13:6] data_byte, [15:14] 0
    output logic [M_TUSER_W-1:0]  m_axis_tuser   // [0] data_valid, [1] done_res, [3:2] status
);

    localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN);

    // configuration registers
    logic [BYTE_W-1:0] r_header;
    logic [TICK_W-1:0] r_timeout;

    // frame state
    t_phase            r_phase, n_phase;
    logic [CMD_W-1:0]  r_exp_cmd, n_exp_cmd;
    logic [CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;

    // output register
    logic               r_out_valid;
    logic               r_out_dv, n_out_dv;
    logic [INDEX_W-1:0] r_out_idx, n_out_idx;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_done, n_out_done;
    t_status            r_out_status, n_out_status;

    logic              in_acc;
    t_opcode           in_op;
    logic [CMD_W-1:0]  in_cmd;
    logic [BYTE_W-1:0] in_byte;
    logic [TICK_W-1:0] elapsed_inc;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_opcode'(s_axis_tuser);
    assign in_cmd        = s_axis_tdata[CMD_W-1:0];
    assign in_byte       = s_axis_tdata[CMD_W +: BYTE_W];
    assign elapsed_inc   = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + TICK_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_HEADER:  r_header  <= i_cfg_wdata[BYTE_W-1:0];
                REG_TIMEOUT: r_timeout <= i_cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_exp_cmd    = r_exp_cmd;
        n_byte_cnt   = r_byte_cnt;
        n_xor        = r_xor;
        n_elapsed    = r_elapsed;
        n_out_dv     = 1'b0;
        n_out_idx    = '0;
        n_out_byte   = '0;
        n_out_done   = 1'b0;
        n_out_status = ST_OK;

        case (in_op)
            OP_START: begin
                n_exp_cmd  = in_cmd;
                n_xor      = in_cmd;
                n_byte_cnt = '0;
                n_elapsed  = '0;
                n_phase    = PH_HUNT;
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= r_timeout) begin
                        n_phase      = PH_IDLE;
                        n_out_done   = 1'b1;
                        n_out_status = ST_TIMEOUT;
                    end
                end
            end
            OP_BYTE: begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_HUNT: begin
                        if (in_byte == r_header) begin
                            n_phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (in_byte != r_exp_cmd) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_byte_cnt = '0;
                            n_xor      = r_exp_cmd;
                            n_phase    = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_out_dv   = 1'b1;
                        n_out_idx  = INDEX_W'(r_byte_cnt);
                        n_out_byte = in_byte;
                        n_xor      = r_xor ^ in_byte;
                        n_byte_cnt = r_byte_cnt + CNT_W'(1);
                        if (n_byte_cnt >= CNT_LAST) begin
                            n_phase = PH_CS;
                        end
                    end
                    PH_CS: begin
                        n_phase      = PH_IDLE;
                        n_out_done   = 1'b1;
                        n_out_status = (in_byte == r_xor) ? ST_OK : ST_CS_ERR;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_exp_cmd  <= '0;
            r_byte_cnt <= '0;
            r_xor      <= '0;
            r_elapsed  <= '0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_exp_cmd  <= n_exp_cmd;
            r_byte_cnt <= n_byte_cnt;
            r_xor      <= n_xor;
            r_elapsed  <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_dv     <= n_out_dv;
            r_out_idx    <= n_out_idx;
            r_out_byte   <= n_out_byte;
            r_out_done   <= n_out_done;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - INDEX_W - BYTE_W){1'b0}}, r_out_byte, r_out_idx};
    assign m_axis_tuser  = {r_out_status, r_out_done, r_out_dv};

    // a result never carries payload and an end at once
    a_dv_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_dv && r_out_done))
        else $error("payload and done flagged in one result");

    // payload counter stays within the frame
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= CNT_LAST)
        else $error("payload count beyond frame length");

    // every ended receive leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_out_done) |=> (r_phase == PH_IDLE))
        else $error("receive ended but block not idle");

    // a start re-arms the hunt with a cleared tick count
    a_start_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_START) |=> (r_phase == PH_HUNT && r_elapsed == '0))
        else $error("start did not arm the hunt");

    // payload results only come from the data phase
    a_dv_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_out_dv) |-> (r_phase == PH_DATA))
        else $error("payload emitted outside data phase");

endmodule
